@@ rtl/dfs_pkg.sv @@
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants
// Field widths, function codes and the command/status bundles that pass
// between the search controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	// Item field widths
	localparam int FIELD_W   = 5;
	localparam int ROW_BITS  = 32;
	localparam int NODES_DEF = 32;

	// Function codes of an input item
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;    // write one adjacency row
		logic init;    // clear visited map, push the root
		logic step;    // one push or pop of the walk
		logic finish;  // emit the final result of a search
	} dfs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_done;  // stack empty
		logic stall;      // next edge has nowhere to go yet
		logic out_free;   // output register can take a result
	} dfs_status_t;

endpackage

`default_nettype wire

@@ rtl/dfs_if.sv @@
// ----------------------------------------------------------------------------
// dfs_in_if / dfs_out_if: item channels
// Valid/ready channels carrying input items and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_in_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [dfs_pkg::FIELD_W-1:0]  row_index;
	logic [dfs_pkg::ROW_BITS-1:0] row_bits;
	logic [dfs_pkg::FIELD_W-1:0]  start_node;

	modport source (output valid, func, row_index, row_bits, start_node, input ready);
	modport sink   (input valid, func, row_index, row_bits, start_node, output ready);
endinterface

interface dfs_out_if;
	logic                        valid;
	logic                        ready;
	logic [dfs_pkg::FIELD_W-1:0] parent_node;
	logic [dfs_pkg::FIELD_W-1:0] child_node;
	logic                        edge_found;
	logic                        last;

	modport source (output valid, parent_node, child_node, edge_found, last, input ready);
	modport sink   (input valid, parent_node, child_node, edge_found, last, output ready);
endinterface

`default_nettype wire

@@ rtl/dfs_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// dfs_spanning_tree: depth-first search spanning tree
// Holds an adjacency bit matrix, loaded one row per item, and on a search item
// walks the graph depth first, emitting each tree edge in discovery order.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                   | items
//  --------+-----+------------------------------------------+------------------
//  din     | in  | func, row_index, row_bits, start_node    | load or search
//  dout    | out | parent_node, child_node, edge_found, last| 1..31 per search
//
//  A load item writes one adjacency row. A search pushes the root, then
//  takes one step per push or pop of the vertex stack, held while the walk
//  stalls, and closes by emitting the final result of the search.
//  Reset clears the adjacency rows and all control state at once.
//  A stalled output holds the walk only when a new edge needs the output
//  register; din is not taken until the search's last result is registered.
//
`default_nettype none

module dfs_spanning_tree #(
	parameter int NODES = dfs_pkg::NODES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dfs_in_if.sink   din,
	dfs_out_if.source dout
);

	dfs_pkg::dfs_cmd_t    cmd;
	dfs_pkg::dfs_status_t status;

	dfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_func  (din.func),
		.in_ready (din.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dfs_dpath #(
		.NODES (NODES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.row_index   (din.row_index),
		.row_bits    (din.row_bits),
		.start_node  (din.start_node),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.parent_node (dout.parent_node),
		.child_node  (dout.child_node),
		.edge_found  (dout.edge_found),
		.last        (dout.last)
	);

endmodule

`default_nettype wire

@@ rtl/dfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// dfs_ctrl: search sequencer
// Takes input items, starts loads and searches, and steps the walk until the
// stack empties, then has the final result emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_func,
	output logic                      in_ready,
	input  wire dfs_pkg::dfs_status_t status,
	output dfs_pkg::dfs_cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Commands
	always_comb begin
		cmd.load   = accept && (in_func == dfs_pkg::FUNC_LOAD);
		cmd.init   = accept && (in_func == dfs_pkg::FUNC_SEARCH);
		cmd.step   = (state_q == S_WALK) && !status.walk_done && !status.stall;
		cmd.finish = (state_q == S_FLUSH) && status.out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (in_func == dfs_pkg::FUNC_SEARCH)) state_q <= S_WALK;
				end
				S_WALK: begin
					if (status.walk_done) state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dfs_dpath.sv @@
// ----------------------------------------------------------------------------
// dfs_dpath: search datapath
// Adjacency rows, visited map, vertex stack, priority encoder, and a one-edge
// holding register in front of the output register so the final edge can be
// marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_dpath #(
	parameter int NODES = dfs_pkg::NODES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dfs_pkg::dfs_cmd_t            cmd,
	output dfs_pkg::dfs_status_t              status,
	input  wire logic [dfs_pkg::FIELD_W-1:0]  row_index,
	input  wire logic [dfs_pkg::ROW_BITS-1:0] row_bits,
	input  wire logic [dfs_pkg::FIELD_W-1:0]  start_node,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [dfs_pkg::FIELD_W-1:0]       parent_node,
	output logic [dfs_pkg::FIELD_W-1:0]       child_node,
	output logic                              edge_found,
	output logic                              last
);

	// Only the loaded row bits can name a neighbor
	localparam int ROW_W = (NODES < dfs_pkg::ROW_BITS) ? NODES : dfs_pkg::ROW_BITS;
	localparam int VW    = $clog2(ROW_W);
	localparam int DW    = $clog2(ROW_W + 1);

	logic [ROW_W-1:0] adj_q [ROW_W];
	logic [ROW_W-1:0] visited_q;
	logic [VW-1:0]    stack_q [ROW_W];
	logic [DW-1:0]    depth_q;
	logic [VW-1:0]    vtx_q;         // top of stack
	logic [dfs_pkg::FIELD_W-1:0] start_q;

	logic             pend_valid_q;
	logic [VW-1:0]    pend_parent_q;
	logic [VW-1:0]    pend_child_q;

	logic             out_valid_q;
	logic [dfs_pkg::FIELD_W-1:0] out_parent_q;
	logic [dfs_pkg::FIELD_W-1:0] out_child_q;
	logic             out_edge_q;
	logic             out_last_q;

	logic [ROW_W-1:0] cand;
	logic             cand_any;
	logic [VW-1:0]    next_v;
	logic [DW-1:0]    below;
	logic             out_free;
	logic             row_ok;
	logic             start_ok;

	assign row_ok   = 32'(row_index) < ROW_W;
	assign start_ok = 32'(start_node) < ROW_W;

	// Unvisited neighbors of the top vertex, lowest index first
	assign cand     = adj_q[vtx_q] & ~visited_q;
	assign cand_any = |cand;

	always_comb begin
		next_v = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (cand[i]) next_v = VW'(i);
		end
	end

	assign below    = depth_q - DW'(2);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status.walk_done = (depth_q == '0);
		status.stall     = cand_any && pend_valid_q && !out_free;
		status.out_free  = out_free;
	end

	// Adjacency rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_W; i++) adj_q[i] <= '0;
		end else if (cmd.load && row_ok) begin
			adj_q[row_index[VW-1:0]] <= row_bits[ROW_W-1:0];
		end
	end

	// Walk control: visited map, depth, pending edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q    <= '0;
			depth_q      <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.init) begin
			visited_q    <= start_ok ? (ROW_W'(1) << start_node[VW-1:0]) : '0;
			depth_q      <= start_ok ? DW'(1) : '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.step) begin
			if (cand_any) begin
				visited_q    <= visited_q | (ROW_W'(1) << next_v);
				depth_q      <= depth_q + DW'(1);
				pend_valid_q <= 1'b1;
			end else begin
				depth_q <= depth_q - DW'(1);
			end
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	// Stack, top vertex and pending edge payload
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			stack_q[0] <= start_node[VW-1:0];
			vtx_q      <= start_node[VW-1:0];
			start_q    <= start_node;
		end else if (cmd.step) begin
			if (cand_any) begin
				stack_q[depth_q[VW-1:0]] <= next_v;
				vtx_q                    <= next_v;
				pend_parent_q            <= vtx_q;
				pend_child_q             <= next_v;
			end else begin
				vtx_q <= stack_q[below[VW-1:0]];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.step && cand_any && pend_valid_q) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && cand_any && pend_valid_q) begin
			out_parent_q <= dfs_pkg::FIELD_W'(pend_parent_q);
			out_child_q  <= dfs_pkg::FIELD_W'(pend_child_q);
			out_edge_q   <= 1'b1;
			out_last_q   <= 1'b0;
		end else if (cmd.finish) begin
			if (pend_valid_q) begin
				out_parent_q <= dfs_pkg::FIELD_W'(pend_parent_q);
				out_child_q  <= dfs_pkg::FIELD_W'(pend_child_q);
				out_edge_q   <= 1'b1;
			end else begin
				// no edge found: report the root alone
				out_parent_q <= start_q;
				out_child_q  <= start_q;
				out_edge_q   <= 1'b0;
			end
			out_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign parent_node = out_parent_q;
	assign child_node  = out_child_q;
	assign edge_found  = out_edge_q;
	assign last        = out_last_q;

endmodule

`default_nettype wire

@@ rtl/dfs_chk.sv @@
// ----------------------------------------------------------------------------
// dfs_chk: port checker
// Watches the top level's channels for ordering and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_func,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dfs_pkg::FIELD_W-1:0] parent_node,
	input wire logic [dfs_pkg::FIELD_W-1:0] child_node,
	input wire logic                        edge_found,
	input wire logic                        last
);

	// A search blocks new items on the next cycle
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_func == dfs_pkg::FUNC_SEARCH) |=> !in_ready)
		else $error("input taken right after a search started");

	// A result without an edge is the whole search
	a_noedge_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !edge_found |-> last)
		else $error("no-edge result not marked last");

	// A result without an edge reports the root on both sides
	a_noedge_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !edge_found |-> parent_node == child_node)
		else $error("no-edge result with differing vertices");

	// A tree edge never loops on itself
	a_edge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_found |-> parent_node != child_node)
		else $error("tree edge is a self loop");

	// Result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parent_node)
			&& $stable(child_node) && $stable(last))
		else $error("stalled result changed");

endmodule

bind dfs_spanning_tree dfs_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.in_func     (din.func),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.parent_node (dout.parent_node),
	.child_node  (dout.child_node),
	.edge_found  (dout.edge_found),
	.last        (dout.last)
);

`default_nettype wire
